// ----- hw/rtl/pws_pkg.sv -----
`timescale 1ns / 1ps

package pws_pkg;

	// Defaults for the top-level parameters.
	localparam int MAX_MOTIF_LEN_DEF = 32;
	localparam int SCORE_BITS_DEF    = 16;

	// Fixed field widths.
	localparam int CFG_W      = 6;
	localparam int IDX_W      = 5;
	localparam int IN_SCORE_W = 16;
	localparam int BASE_W     = 3;
	localparam int MATCH_W    = 16;
	localparam int RAW_W      = 21;

	// Queue between front and back.
	localparam int QUEUE_DEPTH = 4;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [CFG_W-1:0] MOTIF_LEN_RST = CFG_W'(1);

	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_SCORE = 1'b1;

	localparam logic [BASE_W-1:0] BASE_A = 3'd0;
	localparam logic [BASE_W-1:0] BASE_C = 3'd1;
	localparam logic [BASE_W-1:0] BASE_G = 3'd2;
	localparam logic [BASE_W-1:0] BASE_T = 3'd3;
	localparam logic [BASE_W-1:0] BASE_N = 3'd4;

	typedef struct packed {
		logic                  action;
		logic [IDX_W-1:0]      entry_index;
		logic [IN_SCORE_W-1:0] score_a;
		logic [IN_SCORE_W-1:0] score_c;
		logic [IN_SCORE_W-1:0] score_g;
		logic [IN_SCORE_W-1:0] score_t;
		logic [BASE_W-1:0]     base;
		logic                  use_complement;
	} in_item_t;

	typedef struct packed {
		logic [MATCH_W-1:0] match_score;
		logic [RAW_W-1:0]   raw_sum;
	} out_item_t;

	typedef enum logic [2:0] {
		BK_ACCUM,
		BK_PREP,
		BK_SCALE,
		BK_DIV,
		BK_DONE
	} back_state_t;

endpackage

// ----- hw/rtl/pws_ram.sv -----
`timescale 1ns / 1ps

module pws_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 32
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- hw/rtl/pws_front.sv -----
`timescale 1ns / 1ps

module pws_front import pws_pkg::*; #(
	parameter int MAX_MOTIF_LEN = MAX_MOTIF_LEN_DEF,
	parameter int SCORE_BITS    = SCORE_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  in_item_t                  item,
	input  logic                      cfg_we,
	input  logic [CFG_W-1:0]          cfg_wdata,
	input  logic [QCNT_W-1:0]         qcount,
	output logic                      busy,
	output logic                      push,
	output logic [2+3*SCORE_BITS-1:0] push_data
);

	localparam int SB    = SCORE_BITS;
	localparam int POS_W = $clog2(MAX_MOTIF_LEN + 1);
	localparam int COL_W = (MAX_MOTIF_LEN > 1) ? $clog2(MAX_MOTIF_LEN) : 1;
	localparam int ROW_W = 6 * SB;

	logic [CFG_W-1:0] len_q;
	logic [POS_W-1:0] pos_q;
	logic             cmp_q;
	logic [POS_W-1:0] len_eff;
	logic             cmp_now;
	logic [POS_W-1:0] rcol;
	logic [COL_W-1:0] rd_col;
	logic [COL_W-1:0] wr_col;
	logic             last_now;
	logic             acc_load;
	logic             acc_score;
	logic [SB-1:0]    ld_score [4];
	logic [SB-1:0]    ld_max;
	logic [SB-1:0]    ld_min;
	logic [ROW_W-1:0] wr_row;
	logic [ROW_W-1:0] rd_row;

	logic              valid_s1;
	logic              first_s1;
	logic              last_s1;
	logic              cmp_s1;
	logic [BASE_W-1:0] base_s1;

	logic [SB-1:0] sa, sc, sg, st, smin, smax, sel;

	// One slot is held back for the item still in the read stage.
	assign busy = ({1'b0, qcount} + (QCNT_W+1)'(valid_s1)) >= (QCNT_W+1)'(QUEUE_DEPTH);

	assign acc_load  = start && !busy && (item.action == ACT_LOAD);
	assign acc_score = start && !busy && (item.action == ACT_SCORE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= MOTIF_LEN_RST;
		end else if (cfg_we) begin
			len_q <= cfg_wdata;
		end
	end

	always_comb begin
		if (len_q == '0) begin
			len_eff = POS_W'(1);
		end else if (int'(len_q) > MAX_MOTIF_LEN) begin
			len_eff = POS_W'(MAX_MOTIF_LEN);
		end else begin
			len_eff = POS_W'(len_q);
		end
	end

	assign cmp_now = (pos_q == '0) ? item.use_complement : cmp_q;

	always_comb begin
		if (!cmp_now) begin
			rcol = pos_q;
		end else if (pos_q < len_eff) begin
			rcol = len_eff - POS_W'(1) - pos_q;
		end else begin
			rcol = '0;
		end
	end

	assign rd_col   = COL_W'(rcol);
	assign last_now = ({1'b0, pos_q} + (POS_W+1)'(1)) >= {1'b0, len_eff};

	// The column index wraps at the matrix depth; built as a small table.
	always_comb begin
		wr_col = '0;
		for (int k = 0; k < 2**IDX_W; k++) begin
			if (item.entry_index == IDX_W'(k)) begin
				wr_col = COL_W'(k % MAX_MOTIF_LEN);
			end
		end
	end

	assign ld_score[0] = SB'(item.score_a);
	assign ld_score[1] = SB'(item.score_c);
	assign ld_score[2] = SB'(item.score_g);
	assign ld_score[3] = SB'(item.score_t);

	always_comb begin
		ld_max = ld_score[0];
		ld_min = ld_score[0];
		for (int k = 1; k < 4; k++) begin
			if (ld_score[k] > ld_max) begin
				ld_max = ld_score[k];
			end
			if (ld_score[k] < ld_min) begin
				ld_min = ld_score[k];
			end
		end
	end

	assign wr_row = {ld_max, ld_min, ld_score[3], ld_score[2], ld_score[1], ld_score[0]};

	pws_ram #(
		.WIDTH(ROW_W),
		.DEPTH(MAX_MOTIF_LEN)
	) u_matrix (
		.clk  (clk),
		.we   (acc_load),
		.waddr(wr_col),
		.wdata(wr_row),
		.raddr(rd_col),
		.rdata(rd_row)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			cmp_q    <= 1'b0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= acc_score;
			if (acc_score) begin
				cmp_q <= cmp_now;
				pos_q <= last_now ? '0 : pos_q + POS_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc_score) begin
			first_s1 <= (pos_q == '0);
			last_s1  <= last_now;
			cmp_s1   <= cmp_now;
			base_s1  <= item.base;
		end
	end

	assign sa   = rd_row[SB-1:0];
	assign sc   = rd_row[2*SB-1:SB];
	assign sg   = rd_row[3*SB-1:2*SB];
	assign st   = rd_row[4*SB-1:3*SB];
	assign smin = rd_row[5*SB-1:4*SB];
	assign smax = rd_row[6*SB-1:5*SB];

	// Complement mode swaps A with T and C with G; N and unused codes add the minimum.
	always_comb begin
		unique case (base_s1)
			BASE_A:  sel = cmp_s1 ? st : sa;
			BASE_C:  sel = cmp_s1 ? sg : sc;
			BASE_G:  sel = cmp_s1 ? sc : sg;
			BASE_T:  sel = cmp_s1 ? sa : st;
			default: sel = smin;
		endcase
	end

	assign push      = valid_s1;
	assign push_data = {first_s1, last_s1, sel, smax, smin};

	property p_last_rewinds;
		@(posedge clk) disable iff (!arst_n)
		acc_score && last_now |=> (pos_q == '0);
	endproperty
	a_last_rewinds: assert property (p_last_rewinds)
		else $error("window position did not return to zero after the last base");

	property p_no_load_in_stage;
		@(posedge clk) disable iff (!arst_n)
		acc_load |=> !valid_s1;
	endproperty
	a_no_load_in_stage: assert property (p_no_load_in_stage)
		else $error("load item reached the queue");

endmodule

// ----- hw/rtl/pws_queue.sv -----
`timescale 1ns / 1ps

module pws_queue #(
	parameter int WIDTH = 50,
	parameter int DEPTH = 4
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  logic [WIDTH-1:0]             push_data,
	input  logic                         pop,
	output logic [WIDTH-1:0]             pop_data,
	output logic [$clog2(DEPTH+1)-1:0]   count
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] head_q;
	logic [PTR_W-1:0] tail_q;
	logic [CNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		ptr_next = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				tail_q <= ptr_next(tail_q);
			end
			if (pop) begin
				head_q <= ptr_next(head_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[tail_q] <= push_data;
		end
	end

	assign pop_data = slot_q[head_q];
	assign count    = count_q;

	property p_no_overflow;
		@(posedge clk) disable iff (!arst_n)
		push |-> (count_q < CNT_W'(DEPTH));
	endproperty
	a_no_overflow: assert property (p_no_overflow)
		else $error("item pushed into a full queue");

	property p_no_underflow;
		@(posedge clk) disable iff (!arst_n)
		pop |-> (count_q != '0);
	endproperty
	a_no_underflow: assert property (p_no_underflow)
		else $error("item popped from an empty queue");

endmodule

// ----- hw/rtl/pws_back.sv -----
`timescale 1ns / 1ps

module pws_back import pws_pkg::*; #(
	parameter int MAX_MOTIF_LEN = MAX_MOTIF_LEN_DEF,
	parameter int SCORE_BITS    = SCORE_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      avail,
	input  logic [2+3*SCORE_BITS-1:0] pop_data,
	output logic                      pop,
	output logic                      done,
	output out_item_t                 result
);

	localparam int SB      = SCORE_BITS;
	localparam int ACC_RAW = SB + $clog2(MAX_MOTIF_LEN + 1);
	localparam int ACC_W   = (ACC_RAW > RAW_W) ? ACC_RAW : RAW_W;
	localparam int DCNT_W  = $clog2(MATCH_W);

	back_state_t state_q, state_d;

	logic             in_first, in_last;
	logic [SB-1:0]    in_score, in_max, in_min;

	logic [ACC_W-1:0]         sum_q, max_q, min_q;
	logic [ACC_W-1:0]         num_q, range_q, rem_q;
	logic                     zero_q;
	logic [MATCH_W-1:0]       dlo_q, quo_q;
	logic [DCNT_W-1:0]        cnt_q;
	logic [ACC_W+MATCH_W-1:0] scaled;
	logic [ACC_W:0]           shifted, trial;
	logic                     fits;

	assign in_first = pop_data[2+3*SB-1];
	assign in_last  = pop_data[2+3*SB-2];
	assign in_score = pop_data[3*SB-1:2*SB];
	assign in_max   = pop_data[2*SB-1:SB];
	assign in_min   = pop_data[SB-1:0];

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_ACCUM: begin
				if (avail && in_last) begin
					state_d = BK_PREP;
				end
			end
			BK_PREP:  state_d = BK_SCALE;
			BK_SCALE: state_d = BK_DIV;
			BK_DIV: begin
				if (cnt_q == DCNT_W'(MATCH_W - 1)) begin
					state_d = BK_DONE;
				end
			end
			BK_DONE:  state_d = BK_ACCUM;
			default:  state_d = BK_ACCUM;
		endcase
	end

	always_comb begin
		pop  = 1'b0;
		done = 1'b0;
		unique case (state_q)
			BK_ACCUM: pop  = avail;
			BK_DONE:  done = 1'b1;
			default: begin
				pop  = 1'b0;
				done = 1'b0;
			end
		endcase
	end

	// num * 65535 is num shifted up by the fraction width, minus num.
	assign scaled  = {num_q, MATCH_W'(0)} - (ACC_W+MATCH_W)'(num_q);
	assign shifted = {rem_q, dlo_q[MATCH_W-1]};
	assign trial   = shifted - {1'b0, range_q};
	assign fits    = shifted >= {1'b0, range_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_ACCUM;
			sum_q   <= '0;
			max_q   <= '0;
			min_q   <= '0;
		end else begin
			state_q <= state_d;
			if (pop) begin
				sum_q <= (in_first ? '0 : sum_q) + ACC_W'(in_score);
				max_q <= (in_first ? '0 : max_q) + ACC_W'(in_max);
				min_q <= (in_first ? '0 : min_q) + ACC_W'(in_min);
			end
		end
	end

	// Every column score lies between its minimum and maximum, so the sum never
	// exceeds the maximum sum and the quotient fits in the 16 fraction bits.
	always_ff @(posedge clk) begin
		unique case (state_q)
			BK_PREP: begin
				range_q <= (max_q > min_q) ? (max_q - min_q) : '0;
				zero_q  <= (max_q <= min_q) || (sum_q <= min_q);
				num_q   <= sum_q - min_q;
			end
			BK_SCALE: begin
				rem_q <= scaled[ACC_W+MATCH_W-1:MATCH_W];
				dlo_q <= scaled[MATCH_W-1:0];
				cnt_q <= '0;
			end
			BK_DIV: begin
				rem_q <= fits ? trial[ACC_W-1:0] : shifted[ACC_W-1:0];
				quo_q <= {quo_q[MATCH_W-2:0], fits};
				dlo_q <= {dlo_q[MATCH_W-2:0], 1'b0};
				cnt_q <= cnt_q + DCNT_W'(1);
			end
			default: begin
			end
		endcase
	end

	assign result.match_score = zero_q ? '0 : quo_q;
	assign result.raw_sum     = sum_q[RAW_W-1:0];

	property p_strobe_single;
		@(posedge clk) disable iff (!arst_n)
		done |=> !done;
	endproperty
	a_strobe_single: assert property (p_strobe_single)
		else $error("result strobe held for more than one cycle");

	property p_prep_after_last;
		@(posedge clk) disable iff (!arst_n)
		(state_q == BK_PREP) |-> $past(pop);
	endproperty
	a_prep_after_last: assert property (p_prep_after_last)
		else $error("division started without a closing base");

	property p_no_pop_while_dividing;
		@(posedge clk) disable iff (!arst_n)
		(state_q == BK_DIV) |-> !pop && !done;
	endproperty
	a_no_pop_while_dividing: assert property (p_no_pop_while_dividing)
		else $error("queue drained or result shown during division");

endmodule

// ----- hw/rtl/pwm_window_scorer_unit.sv -----
`timescale 1ns / 1ps
// Throughput: one item per cycle while the 4-entry queue has room; each window then holds
// the back end during normalization (a 16-step restoring divider), so it pops no further
// bases until that window's result is strobed.
// Reset (arst_n low, asynchronous): window empty, accumulators zero, motif_length 1;
// matrix columns are undefined until loaded. The receiver cannot stall results.
module pwm_window_scorer_unit import pws_pkg::*; #(
	parameter int MAX_MOTIF_LEN = MAX_MOTIF_LEN_DEF,
	parameter int SCORE_BITS    = SCORE_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  in_item_t         item,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata,
	output logic             done,
	output out_item_t        result
);

	localparam int ENT_W = 2 + 3 * SCORE_BITS;

	logic              push;
	logic [ENT_W-1:0]  push_data;
	logic              pop;
	logic [ENT_W-1:0]  pop_data;
	logic [QCNT_W-1:0] qcount;

	pws_front #(
		.MAX_MOTIF_LEN(MAX_MOTIF_LEN),
		.SCORE_BITS   (SCORE_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.item     (item),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.qcount   (qcount),
		.busy     (busy),
		.push     (push),
		.push_data(push_data)
	);

	pws_queue #(
		.WIDTH(ENT_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.pop      (pop),
		.pop_data (pop_data),
		.count    (qcount)
	);

	pws_back #(
		.MAX_MOTIF_LEN(MAX_MOTIF_LEN),
		.SCORE_BITS   (SCORE_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.avail   (qcount != '0),
		.pop_data(pop_data),
		.pop     (pop),
		.done    (done),
		.result  (result)
	);

endmodule

// ----- bench/tb_pwm_window_scorer_unit.sv -----
`timescale 1ns / 1ps

module tb_pwm_window_scorer_unit;
	import pws_pkg::*;

	localparam int NCOL          = MAX_MOTIF_LEN_DEF;
	localparam int SETTLE_CYCLES = 40;
	localparam int STALL_LIMIT   = 5000;
	localparam int RANDOM_ITEMS  = 1050;

	// Base codes past N; the block treats them as unknown bases.
	localparam logic [BASE_W-1:0] BASE_UNDEF_LO = 3'd5;
	localparam logic [BASE_W-1:0] BASE_UNDEF_HI = 3'd7;

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	in_item_t         in_item;
	logic             cfg_we;
	logic [CFG_W-1:0] cfg_wdata;
	logic             done;
	out_item_t        out_result;

	pwm_window_scorer_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (in_item),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.done      (done),
		.result    (out_result)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Matrix and window state mirrored from the accepted items.
	logic [IN_SCORE_W-1:0] col_score [NCOL][4];
	logic [IN_SCORE_W-1:0] col_hi [NCOL];
	logic [IN_SCORE_W-1:0] col_lo [NCOL];
	logic [RAW_W-1:0]      acc_sum;
	logic [RAW_W-1:0]      acc_hi;
	logic [RAW_W-1:0]      acc_lo;
	int unsigned           win_pos;
	logic                  comp_latch;
	logic [CFG_W-1:0]      motif_len_reg;

	in_item_t  pending_items[$];
	out_item_t expected_matches[$];

	int error_count     = 0;
	int items_taken     = 0;
	int loads_taken     = 0;
	int windows_checked = 0;
	int len_writes      = 0;
	int burst_left      = 0;
	int gap_left        = 0;
	int idle_cycles     = 0;

	task automatic predict_match(input in_item_t it);
		logic [IN_SCORE_W-1:0] s [4];
		int unsigned           len;
		int unsigned           col;
		int unsigned           b;
		longint unsigned       num;
		longint unsigned       span;
		out_item_t             r;
		if (it.action == ACT_LOAD) begin
			s[0] = it.score_a;
			s[1] = it.score_c;
			s[2] = it.score_g;
			s[3] = it.score_t;
			col_hi[it.entry_index] = s[0];
			col_lo[it.entry_index] = s[0];
			for (int k = 0; k < 4; k++) begin
				col_score[it.entry_index][k] = s[k];
				if (s[k] > col_hi[it.entry_index]) col_hi[it.entry_index] = s[k];
				if (s[k] < col_lo[it.entry_index]) col_lo[it.entry_index] = s[k];
			end
			return;
		end
		if (motif_len_reg == 0) len = 1;
		else if (motif_len_reg > NCOL) len = NCOL;
		else len = 32'(motif_len_reg);
		if (win_pos == 0) begin
			comp_latch = it.use_complement;
			acc_sum = '0;
			acc_hi = '0;
			acc_lo = '0;
		end
		// In complement mode the window runs from the last column down to the first.
		if (comp_latch) col = (win_pos < len) ? len - 1 - win_pos : 0;
		else col = win_pos;
		col = col % NCOL;
		acc_hi = acc_hi + RAW_W'(col_hi[col]);
		acc_lo = acc_lo + RAW_W'(col_lo[col]);
		if (it.base >= BASE_N) begin
			acc_sum = acc_sum + RAW_W'(col_lo[col]);
		end else begin
			b = 32'(it.base);
			if (comp_latch) b = 32'(BASE_T - it.base);
			acc_sum = acc_sum + RAW_W'(col_score[col][b]);
		end
		win_pos++;
		if (win_pos < len) return;
		win_pos = 0;
		r.raw_sum = acc_sum;
		if (acc_hi <= acc_lo || acc_sum <= acc_lo) begin
			r.match_score = '0;
		end else begin
			num = 64'(acc_sum - acc_lo);
			span = 64'(acc_hi - acc_lo);
			num = num * 65535 / span;
			r.match_score = (num > 65535) ? '1 : num[MATCH_W-1:0];
		end
		expected_matches.push_back(r);
	endtask

	function automatic in_item_t random_fill();
		logic [95:0] r;
		r = {$urandom(), $urandom(), $urandom()};
		return r[$bits(in_item_t)-1:0];
	endfunction

	function automatic in_item_t make_load(input int idx, input logic [IN_SCORE_W-1:0] a,
			input logic [IN_SCORE_W-1:0] c, input logic [IN_SCORE_W-1:0] g,
			input logic [IN_SCORE_W-1:0] t);
		in_item_t it;
		it = random_fill();
		it.action = ACT_LOAD;
		it.entry_index = IDX_W'(idx);
		it.score_a = a;
		it.score_c = c;
		it.score_g = g;
		it.score_t = t;
		return it;
	endfunction

	function automatic in_item_t make_base(input logic [BASE_W-1:0] b, input logic comp);
		in_item_t it;
		it = random_fill();
		it.action = ACT_SCORE;
		it.base = b;
		it.use_complement = comp;
		return it;
	endfunction

	function automatic in_item_t random_load();
		in_item_t              it;
		logic [IN_SCORE_W-1:0] v;
		it = random_fill();
		it.action = ACT_LOAD;
		v = IN_SCORE_W'($urandom());
		case ($urandom_range(0, 7))
			0: begin
				// Flat column: contributes nothing to the range.
				it.score_a = v;
				it.score_c = v;
				it.score_g = v;
				it.score_t = v;
			end
			1: begin
				it.score_a = $urandom_range(0, 1) ? '1 : '0;
				it.score_c = $urandom_range(0, 1) ? '1 : '0;
				it.score_g = $urandom_range(0, 1) ? '1 : '0;
				it.score_t = $urandom_range(0, 1) ? '1 : '0;
			end
			2: begin
				it.score_a = v + IN_SCORE_W'($urandom_range(0, 3));
				it.score_c = v + IN_SCORE_W'($urandom_range(0, 3));
				it.score_g = v + IN_SCORE_W'($urandom_range(0, 3));
				it.score_t = v + IN_SCORE_W'($urandom_range(0, 3));
			end
			default: ;
		endcase
		return it;
	endfunction

	function automatic in_item_t random_base();
		in_item_t it;
		it = random_fill();
		it.action = ACT_SCORE;
		if ($urandom_range(0, 9) == 0)
			it.base = BASE_W'($urandom_range(BASE_UNDEF_LO, BASE_UNDEF_HI));
		else it.base = BASE_W'($urandom_range(BASE_A, BASE_N));
		return it;
	endfunction

	function automatic logic [CFG_W-1:0] pick_motif_len();
		case ($urandom_range(0, 19))
			0: return '0;
			1, 2: return CFG_W'(NCOL);
			3, 4: return CFG_W'($urandom_range(NCOL + 1, (1 << CFG_W) - 1));
			5, 6, 7: return CFG_W'($urandom_range(9, NCOL - 1));
			default: return CFG_W'($urandom_range(1, 8));
		endcase
	endfunction

	// Returns once every item is taken, every result is in and the back end has settled.
	task automatic wait_quiet();
		while (pending_items.size() != 0 || start || expected_matches.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_motif_len(input logic [CFG_W-1:0] v);
		wait_quiet();
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		motif_len_reg = v;
		len_writes++;
		@(negedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				predict_match(in_item);
				items_taken++;
				if (in_item.action == ACT_LOAD) loads_taken++;
			end
			if (!start || !busy) begin
				if (gap_left > 0) begin
					gap_left--;
					start <= 1'b0;
				end else if (pending_items.size() != 0) begin
					in_item <= pending_items.pop_front();
					start <= 1'b1;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
							: $urandom_range(1, 12);
						case ($urandom_range(0, 9))
							0: gap_left = $urandom_range(8, 20);
							1, 2, 3: gap_left = 0;
							default: gap_left = $urandom_range(1, 4);
						endcase
					end
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : result_check
		out_item_t want;
		if (arst_n && done) begin
			if (expected_matches.size() == 0) begin
				$error("unexpected result: match_score %0d raw_sum %0d",
					out_result.match_score, out_result.raw_sum);
				error_count++;
			end else begin
				want = expected_matches.pop_front();
				if (out_result.match_score !== want.match_score) begin
					$error("match_score: expected %0d, got %0d", want.match_score,
						out_result.match_score);
					error_count++;
				end
				if (out_result.raw_sum !== want.raw_sum) begin
					$error("raw_sum: expected %0d, got %0d", want.raw_sum, out_result.raw_sum);
					error_count++;
				end
				windows_checked++;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("Timeout: no item or result moved for %0d cycles", STALL_LIMIT);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	initial begin : stimulus
		in_item_t it;
		int       n;
		int       random_sent;
		int       phase;
		arst_n = 1'b0;
		start = 1'b0;
		in_item = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		acc_sum = '0;
		acc_hi = '0;
		acc_lo = '0;
		win_pos = 0;
		comp_latch = 1'b0;
		motif_len_reg = MOTIF_LEN_RST;
		random_sent = 0;
		phase = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Every column is loaded before the first base, so no window reads an empty column.
		pending_items.push_back(make_load(0, '0, '1, 16'h1234, 16'h00FF));
		for (int c = 1; c < NCOL - 1; c++) begin
			it = random_load();
			it.entry_index = IDX_W'(c);
			pending_items.push_back(it);
		end
		pending_items.push_back(make_load(NCOL - 1, '1, '1, '1, '1));

		// One-column windows: every base from A to N, an undefined code, complemented bases, and a flat column.
		for (int b = BASE_A; b <= BASE_N; b++)
			pending_items.push_back(make_base(BASE_W'(b), 1'b0));
		pending_items.push_back(make_base(BASE_UNDEF_HI, 1'b0));
		pending_items.push_back(make_base(BASE_T, 1'b1));
		pending_items.push_back(make_base(BASE_C, 1'b1));
		pending_items.push_back(make_load(0, 16'h4000, 16'h4000, 16'h4000, 16'h4000));
		pending_items.push_back(make_base(BASE_G, 1'b0));
		pending_items.push_back(make_load(0, '1, '0, 16'h8000, 16'h0001));

		// Two-column windows, including a column reload in the middle of a window.
		write_motif_len(CFG_W'(2));
		pending_items.push_back(make_base(BASE_A, 1'b1));
		pending_items.push_back(make_base(BASE_G, 1'b0));
		pending_items.push_back(make_base(BASE_N, 1'b0));
		pending_items.push_back(make_base(BASE_UNDEF_LO, 1'b1));
		pending_items.push_back(make_base(BASE_C, 1'b0));
		pending_items.push_back(make_load(1, 16'h0100, 16'h0300, 16'h0200, 16'h0000));
		pending_items.push_back(make_base(BASE_T, 1'b1));

		write_motif_len(CFG_W'(0));
		pending_items.push_back(make_base(BASE_G, 1'b1));

		// Shrink the length to two after three bases of a four-base window.
		write_motif_len(CFG_W'(4));
		for (int i = 0; i < 3; i++) pending_items.push_back(random_base());
		write_motif_len(CFG_W'(2));
		pending_items.push_back(random_base());

		write_motif_len('1);
		while (random_sent < RANDOM_ITEMS) begin
			n = $urandom_range(4, 60);
			if (phase == 4) begin
				write_motif_len(CFG_W'(NCOL));
			end else begin
				case ($urandom_range(0, 5))
					0, 1: write_motif_len(pick_motif_len());
					2: wait_quiet();
					default: ;
				endcase
			end
			for (int i = 0; i < n; i++) begin
				if ($urandom_range(0, 9) == 0) pending_items.push_back(random_load());
				else pending_items.push_back(random_base());
			end
			random_sent += n;
			phase++;
			while (pending_items.size() > 8) @(negedge clk);
		end

		wait_quiet();
		$display("Sent %0d items (%0d column loads) over %0d length settings;",
			items_taken, loads_taken, len_writes + 1);
		$display("checked %0d window scores in forward and complement mode.", windows_checked);
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// ----- pwm_window_scorer_unit.f -----
hw/rtl/pws_pkg.sv
hw/rtl/pws_ram.sv
hw/rtl/pws_front.sv
hw/rtl/pws_queue.sv
hw/rtl/pws_back.sv
hw/rtl/pwm_window_scorer_unit.sv
bench/tb_pwm_window_scorer_unit.sv
